// ===== src/lcdns_pkg.sv =====
`default_nettype none
package lcdns_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int LEVEL_W     = 7;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(99);

	localparam logic [CFG_IDX_W-1:0] CFG_EN_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EN_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic [7:0]        byte_value;
		logic              rs;
		logic [TICK_W-1:0] settle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t wr_entry;
	} fifo_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} fifo_sts_t;

endpackage
`default_nettype wire

// ===== src/char_lcd_nibble_sequencer_unit.sv =====
// Character LCD 4-bit bus sequencer with a write queue.
// Input channel (in_valid/in_ready): func selects a push (byte_value, is_data,
// hold_ticks queued; data writes take the data settle reload at push time) or one
// timer tick that steps the enable-strobe sequencer.
// Output channel (out_valid/out_ready): one result per transaction with the
// current pin levels, dropped flag, queue level and busy status.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 enable high reload,
// 1 enable low reload, 2 data settle reload; always ready, index 3 ignored.
// The result is registered; a tick that pops the queue first passes through
// the ST_POP state for the registered queue RAM read.
// Throughput: one transaction per cycle while results are taken at once;
// none is taken while a pop tick waits in ST_POP. A new transaction is taken
// only in ST_RUN and when the result register is empty or taken that cycle.
// Receiver stall: results hold and in_ready stays low until out_ready.
// Reset: queue empty, sequencer idle, pins low, all reloads 99; no clearing
// pass is needed.
`default_nettype none
module char_lcd_nibble_sequencer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              func,
	input  wire logic [7:0]                        byte_value,
	input  wire logic                              is_data,
	input  wire logic [lcdns_pkg::TICK_W-1:0]      hold_ticks,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   lcd_rs,
	output logic                                   lcd_en,
	output logic [3:0]                             lcd_nibble,
	output logic                                   dropped,
	output logic [lcdns_pkg::LEVEL_W-1:0]          queue_level,
	output logic                                   busy_res,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lcdns_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lcdns_pkg::TICK_W-1:0]      cfg_data
);
	import lcdns_pkg::*;

	typedef enum logic {
		ST_RUN,
		ST_POP
	} ctl_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH1,
		PH_LOW1,
		PH_HIGH2
	} phase_t;

	ctl_state_t        state_q;
	phase_t            phase_q;
	entry_t            cur_q;
	logic [TICK_W-1:0] countdown_q;
	logic              rs_q;
	logic              en_q;
	logic [3:0]        nib_q;
	logic              out_valid_q;
	logic              dropped_q;
	logic [TICK_W-1:0] en_high_q;
	logic [TICK_W-1:0] en_low_q;
	logic [TICK_W-1:0] settle_q;

	fifo_ctl_t fctl;
	fifo_sts_t fsts;
	entry_t    rd_entry;

	logic accept;
	logic is_tick;
	logic need_pop;

	assign in_ready = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_tick  = (func == FUNC_TICK);
	assign need_pop = is_tick && (countdown_q == '0) && (phase_q == PH_IDLE) && !fsts.empty;

	always_comb begin
		fctl.push              = accept && !is_tick && !fsts.full;
		fctl.pop               = accept && need_pop;
		fctl.wr_entry.byte_value = byte_value;
		fctl.wr_entry.rs       = is_data;
		fctl.wr_entry.settle   = is_data ? settle_q : hold_ticks;
	end

	lcdns_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl),
		.sts     (fsts),
		.rd_entry(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			phase_q     <= PH_IDLE;
			cur_q       <= '0;
			countdown_q <= '0;
			rs_q        <= 1'b0;
			en_q        <= 1'b0;
			nib_q       <= '0;
			out_valid_q <= 1'b0;
			dropped_q   <= 1'b0;
			en_high_q   <= TICK_RESET;
			en_low_q    <= TICK_RESET;
			settle_q    <= TICK_RESET;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_EN_HIGH: en_high_q <= cfg_data;
					CFG_EN_LOW:  en_low_q  <= cfg_data;
					CFG_SETTLE:  settle_q  <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_POP: begin
					cur_q       <= rd_entry;
					rs_q        <= rd_entry.rs;
					nib_q       <= rd_entry.byte_value[7:4];
					en_q        <= 1'b1;
					countdown_q <= en_high_q;
					phase_q     <= PH_HIGH1;
					out_valid_q <= 1'b1;
					state_q     <= ST_RUN;
				end
				default: begin
					if (accept) begin
						dropped_q <= !is_tick && fsts.full;
						if (need_pop) begin
							state_q <= ST_POP;
						end else begin
							out_valid_q <= 1'b1;
						end
						if (is_tick) begin
							if (countdown_q != '0) begin
								countdown_q <= countdown_q - TICK_W'(1);
							end else begin
								case (phase_q)
									PH_HIGH1: begin
										en_q        <= 1'b0;
										countdown_q <= en_low_q;
										phase_q     <= PH_LOW1;
									end
									PH_LOW1: begin
										nib_q       <= cur_q.byte_value[3:0];
										en_q        <= 1'b1;
										countdown_q <= en_high_q;
										phase_q     <= PH_HIGH2;
									end
									PH_HIGH2: begin
										en_q        <= 1'b0;
										countdown_q <= cur_q.settle;
										phase_q     <= PH_IDLE;
									end
									default: ;
								endcase
							end
						end
					end
				end
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign lcd_rs      = rs_q;
	assign lcd_en      = en_q;
	assign lcd_nibble  = nib_q;
	assign dropped     = dropped_q;
	assign queue_level = LEVEL_W'(fsts.count);
	assign busy_res    = (phase_q != PH_IDLE) || (countdown_q != '0);

`ifndef SYNTHESIS
	a_pop_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !out_valid_q)
		else $error("result pending during queue read");

	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (out_valid_q && (phase_q == PH_HIGH1) && en_q))
		else $error("pop did not start the high nibble strobe");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q) |-> fsts.full)
		else $error("push dropped while queue not full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fsts.count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

// ===== src/lcdns_ram.sv =====
`default_nettype none
module lcdns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/lcdns_fifo.sv =====
`default_nettype none
module lcdns_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lcdns_pkg::fifo_ctl_t  ctl,
	output lcdns_pkg::fifo_sts_t       sts,
	output lcdns_pkg::entry_t          rd_entry
);
	import lcdns_pkg::*;

	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W-1:0] wptr_q;
	logic [CNT_W-1:0] count_q;
	logic [ENTRY_W-1:0] rdata;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	lcdns_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(wptr_q),
		.wdata(ctl.wr_entry),
		.re   (ctl.pop),
		.raddr(rptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q  <= '0;
			wptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (ctl.pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rd_entry  = entry_t'(rdata);
	assign sts.count = count_q;
	assign sts.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.empty = (count_q == '0);

endmodule
`default_nettype wire
